@@ src/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// LFU frame replacement package
// Shared widths, defaults and limits for the frame replacement unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

   // default geometry
   localparam int FRAMES_DEF     = 20;
   localparam int CANDIDATES_DEF = 128;

   // field widths
   localparam int ID_W    = 7;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 16;
   localparam int STAMP_W = 32;
   localparam int FIU_W   = 5;

   // frames_in_use after reset
   localparam logic [FIU_W-1:0] FIU_RESET = 5'd20;

   // stream payload widths (fields packed from bit 0, padded to bytes)
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

endpackage

`default_nettype wire

@@ src/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/lfu_frame_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// LFU frame replacement unit
// Maps candidate IDs onto a small set of frames with least-frequently-used
// replacement, ties going to the oldest insertion.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one transfer per reference, candidate ID in req_tdata.
//   rsp_* : one transfer per reference: hit in rsp_tuser, slot, evicted ID
//           and reference count in rsp_tdata.
//   csr_* : frames_in_use; the user writes it only while idle, not enforced.
// Sequencing:
//   After reset a clearing pass zeroes all CANDIDATES candidate map entries
//   (128 by default), with req_tready low.
//   A hit passes from the transfer through lookup, count update and result
//   back to req_tready; a reserved ID (zero) goes straight to result. A miss
//   runs lookup, a victim scan of k frames (at most the active frame count),
//   evict, map and result; the scan reads one frame per cycle through one
//   shared compare. The result sits in an output register; a new request is
//   taken while it waits. If the receiver stalls, the next result holds the
//   unit until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_frame_replacement_unit #(
   parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
   parameter int CANDIDATES = lfu_pkg::CANDIDATES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request: [6:0] candidate_id
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [lfu_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: [4:0] slot, [11:5] evicted_id, [27:12] ref_count
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [lfu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // response: [0] hit
   output      logic                           rsp_tuser,
   // configuration: frames_in_use
   input  wire logic                           csr_wr_en,
   input  wire logic [lfu_pkg::FIU_W-1:0]      csr_wr_data
);

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int MAP_W  = $clog2(FRAMES + 1);
   localparam int CIDX_W = $clog2(CANDIDATES);
   localparam int KEY_W  = lfu_pkg::COUNT_W + lfu_pkg::STAMP_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_HIT, ST_SCAN, ST_EVICT, ST_MAP, ST_RESULT
   } state_type;

   // control state
   state_type                     state_ff, state_in;
   logic [CIDX_W-1:0]             clr_ff, clr_in;
   logic [lfu_pkg::FIU_W-1:0]     fiu_ff;
   logic [lfu_pkg::STAMP_W-1:0]   seq_ff, seq_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [lfu_pkg::ID_W-1:0]      id_ff, id_in;
   logic                          id_ok_ff, id_ok_in;
   logic [FIDX_W-1:0]             fidx_ff, fidx_in;
   logic [FIDX_W-1:0]             best_ff, best_in;
   logic [KEY_W-1:0]              best_key_ff, best_key_in;
   logic                          hit_ff, hit_in;
   logic [lfu_pkg::ID_W-1:0]      ev_ff, ev_in;
   logic [lfu_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;

   // output register
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // frame state
   logic [lfu_pkg::ID_W-1:0]      owner_ff [FRAMES];
   logic [lfu_pkg::COUNT_W-1:0]   count_ff [FRAMES];
   logic [lfu_pkg::STAMP_W-1:0]   stamp_ff [FRAMES];
   logic                          cnt_we, fill_we;
   logic [lfu_pkg::COUNT_W-1:0]   cnt_wdata;

   // candidate map memory
   logic                          map_we;
   logic [CIDX_W-1:0]             map_waddr;
   logic [MAP_W-1:0]              map_wdata;
   logic [CIDX_W-1:0]             map_raddr;
   logic [MAP_W-1:0]              map_rdata;

   // helpers
   logic [lfu_pkg::ID_W-1:0]      req_id;
   logic                          req_fire;
   logic [MAP_W-1:0]              active_cnt;
   logic [FIDX_W-1:0]             last_idx;
   logic [lfu_pkg::ID_W-1:0]      cur_owner;
   logic [KEY_W-1:0]              cur_key;
   logic                          take_best;

   assign req_id   = req_tdata[lfu_pkg::ID_W-1:0];
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // active frame count clamped to 1..FRAMES
   always_comb begin
      if (fiu_ff == '0) begin
         active_cnt = MAP_W'(1);
      end else if (32'(fiu_ff) > 32'(FRAMES)) begin
         active_cnt = MAP_W'(FRAMES);
      end else begin
         active_cnt = MAP_W'(fiu_ff);
      end
   end
   assign last_idx = FIDX_W'(active_cnt - MAP_W'(1));

   // shared frame read port and key compare
   assign cur_owner = owner_ff[fidx_ff];
   assign cur_key   = {count_ff[fidx_ff], stamp_ff[fidx_ff]};
   assign take_best = (fidx_ff == '0) || (cur_key < best_key_ff);

   assign map_raddr = CIDX_W'(req_id);

   lfu_ram #(
      .WIDTH (MAP_W),
      .DEPTH (CANDIDATES)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // sequencer next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      id_in        = id_ff;
      id_ok_in     = id_ok_ff;
      fidx_in      = fidx_ff;
      best_in      = best_ff;
      best_key_in  = best_key_ff;
      hit_in       = hit_ff;
      ev_in        = ev_ff;
      cnt_in       = cnt_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      map_we       = 1'b0;
      map_waddr    = clr_ff;
      map_wdata    = '0;
      cnt_we       = 1'b0;
      cnt_wdata    = '0;
      fill_we      = 1'b0;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            clr_in    = clr_ff + CIDX_W'(1);
            if (32'(clr_ff) == 32'(CANDIDATES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               id_in    = req_id;
               id_ok_in = (req_id != '0) && (32'(req_id) < 32'(CANDIDATES));
               hit_in   = 1'b0;
               ev_in    = '0;
               cnt_in   = '0;
               fidx_in  = '0;
               if ((req_id != '0) && (32'(req_id) < 32'(CANDIDATES))) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_LOOKUP: begin
            if (map_rdata != '0) begin
               hit_in   = 1'b1;
               fidx_in  = FIDX_W'(map_rdata - MAP_W'(1));
               state_in = ST_HIT;
            end else begin
               fidx_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_HIT: begin
            cnt_wdata = (count_ff[fidx_ff] != '1) ?
                        count_ff[fidx_ff] + lfu_pkg::COUNT_W'(1) : count_ff[fidx_ff];
            cnt_we    = 1'b1;
            cnt_in    = cnt_wdata;
            state_in  = ST_RESULT;
         end
         ST_SCAN: begin
            // one frame per cycle: first empty wins, else smallest key
            if (cur_owner == '0) begin
               state_in = ST_EVICT;
            end else begin
               if (take_best) begin
                  best_in     = fidx_ff;
                  best_key_in = cur_key;
               end
               if (fidx_ff == last_idx) begin
                  fidx_in  = take_best ? fidx_ff : best_ff;
                  state_in = ST_EVICT;
               end else begin
                  fidx_in = fidx_ff + FIDX_W'(1);
               end
            end
         end
         ST_EVICT: begin
            ev_in   = cur_owner;
            fill_we = 1'b1;
            if ((cur_owner != '0) && (32'(cur_owner) < 32'(CANDIDATES))) begin
               map_we    = 1'b1;
               map_waddr = CIDX_W'(cur_owner);
               map_wdata = '0;
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            map_we    = 1'b1;
            map_waddr = CIDX_W'(id_ff);
            map_wdata = MAP_W'(fidx_ff) + MAP_W'(1);
            cnt_in    = lfu_pkg::COUNT_W'(1);
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_data_in  = {4'b0, cnt_ff, ev_ff,
                               id_ok_ff ? lfu_pkg::SLOT_W'(fidx_ff) : lfu_pkg::SLOT_W'(0)};
               if (id_ok_ff && (seq_ff != '1)) begin
                  seq_in = seq_ff + lfu_pkg::STAMP_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fiu_ff       <= lfu_pkg::FIU_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fiu_ff <= csr_wr_data;
         end
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      id_ok_ff    <= id_ok_in;
      fidx_ff     <= fidx_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      hit_ff      <= hit_in;
      ev_ff       <= ev_in;
      cnt_ff      <= cnt_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // frame owner and count, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            owner_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else if (fill_we) begin
         owner_ff[fidx_ff] <= id_ff;
         count_ff[fidx_ff] <= lfu_pkg::COUNT_W'(1);
      end else if (cnt_we) begin
         count_ff[fidx_ff] <= cnt_wdata;
      end
   end

   // insertion stamps, written on fill only
   always_ff @(posedge clock) begin
      if (fill_we) begin
         stamp_ff[fidx_ff] <= seq_ff;
      end
   end

   // checks
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (MAP_W'(fidx_ff) < active_cnt))
      else $error("victim scan ran past the active frames");

   a_valid_ref_looks_up: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_id != '0) && (32'(req_id) < 32'(CANDIDATES)))
      |=> (state_ff == ST_LOOKUP))
      else $error("valid reference skipped the map lookup");

   a_hit_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_data_ff[27:12] != '0))
      else $error("hit reported with zero reference count");

   a_seq_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (seq_ff >= $past(seq_ff)))
      else $error("sequence stamp went backwards");

endmodule

`default_nettype wire
